@@ rtl/bpm_pkg.sv @@
// ----------------------------------------------------------------------------
// bpm_pkg
// Shared types, register indexes, constants and helpers for the battery
// protection monitor.
// ----------------------------------------------------------------------------
package bpm_pkg;

    // Protection state, encoded as the reported state code
    typedef enum logic [2:0] {
        ST_IDLE        = 3'd0,
        ST_CHARGING    = 3'd1,
        ST_DISCHARGING = 3'd2,
        ST_UNDERVOLT   = 3'd3,
        ST_OVERVOLT    = 3'd4,
        ST_OVERCURRENT = 3'd5
    } t_mode;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_UV_CUT     = 3'd0,
        REG_UV_RELEASE = 3'd1,
        REG_OV_CUT     = 3'd2,
        REG_OV_RELEASE = 3'd3,
        REG_CUR_LIMIT  = 3'd4,
        REG_OC_HOLD    = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic        [15:0] uv_cut;
        logic        [15:0] uv_release;
        logic        [15:0] ov_cut;
        logic        [15:0] ov_release;
        logic signed [15:0] cur_limit;
        logic        [15:0] oc_hold;
    } t_cfg;

    // Pipeline advance strobes, one for each of stages 2 to 4
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } t_adv;

    // Register reset values
    localparam logic [15:0]        RST_UV_CUT     = 16'd1800;
    localparam logic [15:0]        RST_UV_RELEASE = 16'd2000;
    localparam logic [15:0]        RST_OV_CUT     = 16'd2800;
    localparam logic [15:0]        RST_OV_RELEASE = 16'd2700;
    localparam logic signed [15:0] RST_CUR_LIMIT  = 16'sd2000;
    localparam logic [15:0]        RST_OC_HOLD    = 16'd60;

    localparam logic signed [15:0] NOISE_MA      = 16'sd2;
    localparam logic signed [16:0] DIFF_MIN_MV   = 17'sd50;
    localparam logic signed [16:0] OV_RECLOSE_MV = -17'sd5;

    // Reciprocals: q = (x * M) >> S is exact floor(x / d) over the input range
    // energy: x < 2^31, d = 1000 ; power: x < 2^31, d = 10000 ; x < 2^18, d = 5
    localparam logic [31:0] RECIP_1000   = 32'd2199023256;
    localparam int          SHIFT_1000   = 41;
    localparam logic [31:0] RECIP_10000  = 32'd3518437209;
    localparam int          SHIFT_10000  = 45;
    localparam logic [18:0] RECIP_5      = 19'd419431;
    localparam int          SHIFT_5      = 21;

    // Zero out currents inside the noise band
    function automatic logic signed [15:0] f_denoise(input logic signed [15:0] cur);
        logic signed [15:0] res;
        res = cur;
        if ((cur <= NOISE_MA) && (cur >= -NOISE_MA)) begin
            res = '0;
        end
        return res;
    endfunction

    // Magnitude of a 16-bit signed value; -32768 maps to 32768
    function automatic logic [15:0] f_abs16(input logic signed [15:0] val);
        logic [15:0] res;
        res = val[15] ? 16'(-val) : 16'(val);
        return res;
    endfunction

endpackage

@@ rtl/battery_protection_monitor.sv @@
// ----------------------------------------------------------------------------
// battery_protection_monitor
// Per-tick battery protection: lockout state machine, cutoff switch, charge
// and energy bookkeeping, and scaled current, voltage and power values.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                  payload
//  -------  ---------  -------------------------  -------------------------------
//  in       sink       i_in_valid / o_in_stall    current_ma, battery_mv, load_mv
//  out      source     o_out_valid / i_out_stall  state, cutoff, totals, scaled
//  cfg      sink       i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
//  One word per cycle in and out when the output is not stalled. A word passes
//  the input register, the power product stage, the reciprocal multiply stage
//  and the accumulator stage on its way to the output.
//  Reset clears the thresholds to their defaults, the state to idle with the
//  cutoff on, and the accumulators to zero. Each stage advances when the stage
//  behind it is empty or advancing, so bubbles close up; a stalled output
//  holds its word and stalls the input only once every stage is full.
//
// ----------------------------------------------------------------------------
module battery_protection_monitor
    import bpm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic signed [15:0]   i_current_ma,
    input  logic [15:0]          i_battery_mv,
    input  logic [15:0]          i_load_mv,

    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [2:0]           o_state_code,
    output logic                 o_cutoff_on,
    output logic signed [31:0]   o_charge_mas,
    output logic [31:0]          o_energy_out,
    output logic [31:0]          o_energy_in,
    output logic signed [15:0]   o_reg_current,
    output logic [15:0]          o_reg_voltage,
    output logic [15:0]          o_reg_power,

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    t_cfg w_cfg;
    t_adv w_adv;

    // stage valid bits
    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic r_v4;

    logic w_rdy1;
    logic w_rdy2;
    logic w_rdy3;
    logic w_rdy4;
    logic w_accept;

    // input register
    logic signed [15:0] r_cur1;
    logic [15:0]        r_batt1;
    logic [15:0]        r_load1;
    logic signed [15:0] w_cur1;

    // state and cutoff follow their word down the pipe
    t_mode w_mode2;
    logic  w_cutoff2;
    t_mode r_mode3;
    logic  r_cutoff3;
    t_mode r_mode4;
    logic  r_cutoff4;

    // a stage can take a word if it is empty or its word moves on
    assign w_rdy4   = !r_v4 || !i_out_stall;
    assign w_rdy3   = !r_v3 || w_rdy4;
    assign w_rdy2   = !r_v2 || w_rdy3;
    assign w_rdy1   = !r_v1 || w_rdy2;
    assign w_accept = i_in_valid && w_rdy1;

    assign w_adv.s2 = r_v1 && w_rdy2;
    assign w_adv.s3 = r_v2 && w_rdy3;
    assign w_adv.s4 = r_v3 && w_rdy4;

    assign o_in_stall  = !w_rdy1;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_in_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (w_rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // capture the input word
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cur1  <= i_current_ma;
            r_batt1 <= i_battery_mv;
            r_load1 <= i_load_mv;
        end
    end

    // drop currents inside the noise band before any use
    assign w_cur1 = f_denoise(r_cur1);

    bpm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // state registers update as the word enters stage 2
    bpm_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv.s2),
        .i_cfg    (w_cfg),
        .i_cur    (w_cur1),
        .i_batt   (r_batt1),
        .i_load   (r_load1),
        .o_mode   (w_mode2),
        .o_cutoff (w_cutoff2)
    );

    bpm_arith u_arith (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (w_adv),
        .i_cur         (w_cur1),
        .i_batt        (r_batt1),
        .o_charge_mas  (o_charge_mas),
        .o_energy_out  (o_energy_out),
        .o_energy_in   (o_energy_in),
        .o_reg_current (o_reg_current),
        .o_reg_voltage (o_reg_voltage),
        .o_reg_power   (o_reg_power)
    );

    // carry state and cutoff alongside the arithmetic
    always_ff @(posedge i_clk) begin
        if (w_adv.s3) begin
            r_mode3   <= w_mode2;
            r_cutoff3 <= w_cutoff2;
        end
        if (w_adv.s4) begin
            r_mode4   <= r_mode3;
            r_cutoff4 <= r_cutoff3;
        end
    end

    assign o_out_valid  = r_v4;
    assign o_state_code = 3'(r_mode4);
    assign o_cutoff_on  = r_cutoff4;

endmodule

@@ rtl/bpm_cfg.sv @@
// ----------------------------------------------------------------------------
// bpm_cfg
// Threshold register file, written through the configuration port.
// ----------------------------------------------------------------------------
module bpm_cfg
    import bpm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.uv_cut     <= RST_UV_CUT;
            r_cfg.uv_release <= RST_UV_RELEASE;
            r_cfg.ov_cut     <= RST_OV_CUT;
            r_cfg.ov_release <= RST_OV_RELEASE;
            r_cfg.cur_limit  <= RST_CUR_LIMIT;
            r_cfg.oc_hold    <= RST_OC_HOLD;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_UV_CUT:     r_cfg.uv_cut     <= i_cfg_data;
                REG_UV_RELEASE: r_cfg.uv_release <= i_cfg_data;
                REG_OV_CUT:     r_cfg.ov_cut     <= i_cfg_data;
                REG_OV_RELEASE: r_cfg.ov_release <= i_cfg_data;
                REG_CUR_LIMIT:  r_cfg.cur_limit  <= $signed(i_cfg_data);
                REG_OC_HOLD:    r_cfg.oc_hold    <= i_cfg_data;
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/bpm_fsm.sv @@
// ----------------------------------------------------------------------------
// bpm_fsm
// Protection state machine: lockout entry and release, cutoff switch control
// and the tick count since the last state entry.
// ----------------------------------------------------------------------------
module bpm_fsm
    import bpm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  t_cfg               i_cfg,
    input  logic signed [15:0] i_cur,
    input  logic [15:0]        i_batt,
    input  logic [15:0]        i_load,
    output t_mode              o_mode,
    output logic               o_cutoff
);

    t_mode              r_mode;
    t_mode              n_mode;
    logic               r_cutoff;
    logic               n_cutoff;
    logic [31:0]        r_ticks;
    logic [31:0]        n_ticks;
    logic [31:0]        w_tick;
    logic signed [16:0] w_load_minus_batt;
    logic signed [16:0] w_batt_minus_load;
    logic               w_uv_release;
    logic               w_ov_release;
    logic               w_oc_done;
    logic               w_uv_cut;
    logic               w_ov_cut;
    logic               w_oc_trip;

    assign w_tick            = r_ticks + 32'd1;
    assign w_load_minus_batt = $signed({1'b0, i_load}) - $signed({1'b0, i_batt});
    assign w_batt_minus_load = $signed({1'b0, i_batt}) - $signed({1'b0, i_load});
    assign w_uv_release      = i_batt >= i_cfg.uv_release;
    assign w_ov_release      = i_batt <= i_cfg.ov_release;
    assign w_oc_done         = w_tick > {16'd0, i_cfg.oc_hold};
    assign w_uv_cut          = i_batt <= i_cfg.uv_cut;
    assign w_ov_cut          = i_batt >= i_cfg.ov_cut;
    assign w_oc_trip         = i_cur > i_cfg.cur_limit;

    // Next state and tick count
    always_comb begin
        n_mode  = r_mode;
        n_ticks = w_tick;
        case (r_mode)
            ST_UNDERVOLT: begin
                if (w_uv_release) begin
                    n_mode  = ST_IDLE;
                    n_ticks = '0;
                end
            end
            ST_OVERVOLT: begin
                if (w_ov_release) begin
                    n_mode  = ST_IDLE;
                    n_ticks = '0;
                end
            end
            ST_OVERCURRENT: begin
                if (w_oc_done) begin
                    n_mode  = ST_IDLE;
                    n_ticks = '0;
                end
            end
            default: begin
                n_ticks = '0;
                if (w_uv_cut) begin
                    n_mode = ST_UNDERVOLT;
                end else if (w_ov_cut) begin
                    n_mode = ST_OVERVOLT;
                end else if (w_oc_trip) begin
                    n_mode = ST_OVERCURRENT;
                end else if (i_cur > 16'sd0) begin
                    n_mode = ST_DISCHARGING;
                end else if (i_cur < 16'sd0) begin
                    n_mode = ST_CHARGING;
                end else begin
                    n_mode = ST_IDLE;
                end
            end
        endcase
    end

    // Cutoff switch
    always_comb begin
        n_cutoff = r_cutoff;
        case (r_mode)
            ST_UNDERVOLT: begin
                if (!w_uv_release) begin
                    n_cutoff = !(w_load_minus_batt > DIFF_MIN_MV);
                end
            end
            ST_OVERVOLT: begin
                if (!w_ov_release) begin
                    if (w_batt_minus_load > DIFF_MIN_MV) begin
                        n_cutoff = 1'b0;
                    end else if (w_batt_minus_load < OV_RECLOSE_MV) begin
                        n_cutoff = 1'b1;
                    end
                end
            end
            ST_OVERCURRENT: begin
                n_cutoff = !w_oc_done;
            end
            default: begin
                if (!w_uv_cut && !w_ov_cut && !w_oc_trip) begin
                    n_cutoff = 1'b0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= ST_IDLE;
            r_cutoff <= 1'b1;
            r_ticks  <= '0;
        end else if (i_adv) begin
            r_mode   <= n_mode;
            r_cutoff <= n_cutoff;
            r_ticks  <= n_ticks;
        end
    end

    assign o_mode   = r_mode;
    assign o_cutoff = r_cutoff;

endmodule

@@ rtl/bpm_arith.sv @@
// ----------------------------------------------------------------------------
// bpm_arith
// Power product, constant divisions by reciprocal multiply, and the charge
// and energy accumulators. Three register stages behind the input register.
// ----------------------------------------------------------------------------
module bpm_arith
    import bpm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_adv               i_adv,
    input  logic signed [15:0] i_cur,
    input  logic [15:0]        i_batt,
    output logic signed [31:0] o_charge_mas,
    output logic [31:0]        o_energy_out,
    output logic [31:0]        o_energy_in,
    output logic signed [15:0] o_reg_current,
    output logic [15:0]        o_reg_voltage,
    output logic [15:0]        o_reg_power
);

    // stage 2: product and scaled operands
    logic [31:0]        r_prod2;
    logic signed [15:0] r_cur2;
    logic [17:0]        r_cmag4_2;
    logic [17:0]        r_bat4_2;

    // stage 3: quotients
    logic [31:0]        r_q_energy3;
    logic [15:0]        r_q_power3;
    logic [15:0]        r_q_cur3;
    logic [15:0]        r_q_volt3;
    logic signed [15:0] r_cur3;

    // stage 4: results
    logic signed [31:0] r_charge;
    logic [31:0]        r_energy_out;
    logic [31:0]        r_energy_in;
    logic signed [15:0] r_reg_current;
    logic [15:0]        r_reg_voltage;
    logic [15:0]        r_reg_power;

    logic [15:0] w_mag;
    logic [63:0] w_mul_energy;
    logic [63:0] w_mul_power;
    logic [36:0] w_mul_cur;
    logic [36:0] w_mul_volt;

    assign w_mag = f_abs16(i_cur);

    always_ff @(posedge i_clk) begin
        if (i_adv.s2) begin
            r_prod2   <= 32'(w_mag) * 32'(i_batt);
            r_cur2    <= i_cur;
            r_cmag4_2 <= {w_mag, 2'b00};
            r_bat4_2  <= {i_batt, 2'b00};
        end
    end

    assign w_mul_energy = 64'(r_prod2) * 64'(RECIP_1000);
    assign w_mul_power  = 64'(r_prod2) * 64'(RECIP_10000);
    assign w_mul_cur    = 37'(r_cmag4_2) * 37'(RECIP_5);
    assign w_mul_volt   = 37'(r_bat4_2) * 37'(RECIP_5);

    always_ff @(posedge i_clk) begin
        if (i_adv.s3) begin
            r_q_energy3 <= 32'(w_mul_energy[63:SHIFT_1000]);
            r_q_power3  <= w_mul_power[SHIFT_10000+15:SHIFT_10000];
            r_q_cur3    <= w_mul_cur[SHIFT_5+15:SHIFT_5];
            r_q_volt3   <= w_mul_volt[SHIFT_5+15:SHIFT_5];
            r_cur3      <= r_cur2;
        end
    end

    // Accumulators are state: clear on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_charge     <= '0;
            r_energy_out <= '0;
            r_energy_in  <= '0;
        end else if (i_adv.s4) begin
            r_charge <= r_charge + 32'(r_cur3);
            if (r_cur3 > 16'sd0) begin
                r_energy_out <= r_energy_out + r_q_energy3;
            end else begin
                r_energy_in <= r_energy_in + r_q_energy3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.s4) begin
            r_reg_current <= r_cur3[15] ? -$signed(r_q_cur3) : $signed(r_q_cur3);
            r_reg_voltage <= r_q_volt3;
            r_reg_power   <= r_q_power3;
        end
    end

    assign o_charge_mas  = r_charge;
    assign o_energy_out  = r_energy_out;
    assign o_energy_in   = r_energy_in;
    assign o_reg_current = r_reg_current;
    assign o_reg_voltage = r_reg_voltage;
    assign o_reg_power   = r_reg_power;

endmodule
